// ----- src/tcf_pkg.sv -----
// tilt complementary filter: shared types, constants and the atan table
package tcf_pkg;

  localparam int FIELD_W    = 16;
  localparam int GAIN_W     = 20;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // prediction, difference and blend sum widths
  localparam int PRED_W = 37;
  localparam int DIFF_W = 38;
  localparam int SUM_W  = 57;

  // cordic datapath
  localparam int CRD_W      = 26;
  localparam int ATAN_IDX_W = 5;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd640;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd3277;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  localparam logic signed [CRD_W-1:0] ANGLE_180  = 26'sd11796480;
  localparam logic signed [CRD_W-1:0] ANGLE_HALF = 26'sd512;
  localparam logic signed [SUM_W-1:0] ROUND_Q32  = 57'sh0_8000_0000;

  localparam logic signed [FIELD_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [FIELD_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_STEP_GAIN = 2'd0,
    REG_BLEND_WEIGHT   = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_PRED  = 5'b00100,
    ST_BLEND = 5'b01000,
    ST_SAT   = 5'b10000
  } tcf_state_e;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  function automatic logic signed [CRD_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CRD_W-1:0] r;
    case (idx)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/tcf_in_if.sv -----
// input channel: one imu sample per item
interface tcf_in_if import tcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] gyro_rate;
  logic signed [FIELD_W-1:0] accel_side;
  logic signed [FIELD_W-1:0] accel_up;

  modport source (output valid, output gyro_rate, output accel_side, output accel_up,
                  input ready);
  modport sink   (input valid, input gyro_rate, input accel_side, input accel_up,
                  output ready);
endinterface

// ----- src/tcf_out_if.sv -----
// output channel: one filtered angle per item
interface tcf_out_if import tcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] tilt_angle;

  modport source (output valid, output tilt_angle, input ready);
  modport sink   (input valid, input tilt_angle, output ready);
endinterface

// ----- src/tcf_serial_mul.sv -----
// shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle
module tcf_serial_mul import tcf_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic        [BW-1:0]    b_i,
  output logic                    busy_o,
  output logic signed [AW+BW:0]   prod_o
);

  localparam int CNT_W = $clog2(BW);

  logic signed [AW-1:0] a_q;
  logic        [AW:0]   hi_q, hi_d;
  logic        [BW-1:0] lo_q, lo_d;
  logic        [CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic        [AW+1:0] sum;

  // multiplier bits leave lo from the bottom, product bits enter from the top
  always_comb begin
    sum  = {hi_q[AW], hi_q} + (lo_q[0] ? {{2{a_q[AW-1]}}, a_q} : '0);
    hi_d = sum[AW+1:1];
    lo_d = {sum[0], lo_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(BW - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = signed'({hi_q, lo_q});

endmodule

// ----- src/tcf_cordic.sv -----
// vectoring cordic for atan2(side, up) in degrees, one iteration per cycle
module tcf_cordic import tcf_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [FIELD_W-1:0] side_i,
  input  logic signed [FIELD_W-1:0] up_i,
  output logic                      busy_o,
  output logic signed [FIELD_W-1:0] angle_o
);

  localparam int CNT_W = $clog2(STEPS);

  logic signed [CRD_W-1:0] x_q, y_q, z_q;
  logic signed [CRD_W-1:0] x_d, y_d, z_d;
  logic signed [CRD_W-1:0] x0, y0, z0;
  logic signed [CRD_W-1:0] xs, ys, at, zr;
  logic        [CNT_W-1:0] cnt_q;
  logic                    busy_q;
  logic                    zero_q;

  // scale by 256; a negative up axis is turned by 180 degrees first
  always_comb begin
    x0 = signed'({{2{up_i[FIELD_W-1]}}, up_i, 8'b0});
    y0 = signed'({{2{side_i[FIELD_W-1]}}, side_i, 8'b0});
    z0 = '0;
    if (up_i[FIELD_W-1]) begin
      z0 = side_i[FIELD_W-1] ? -ANGLE_180 : ANGLE_180;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = atan_deg_q16(ATAN_IDX_W'(cnt_q));
    if (y_q > 0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      zero_q <= (side_i == '0) && (up_i == '0);
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // degrees q16 to 1/64 degree, rounded
  assign zr      = z_q + ANGLE_HALF;
  assign busy_o  = busy_q;
  assign angle_o = zero_q ? '0 : signed'(zr[CRD_W-1:10]);

endmodule

// ----- src/tilt_complementary_filter_top.sv -----
// tilt complementary filter top: sequencer, config registers, blend and output register
//
// channel  dir  handshake     payload
// in_i     in   valid/ready   gyro_rate, accel_side, accel_up (16 bit signed each)
// out_o    out  valid/ready   tilt_angle (16 bit signed, 1/64 degree)
// cfg      in   cfg_we_i      cfg_idx_i selects gyro_step_gain or blend_weight
//
// an item runs from accept to result as follows: the gyro
// multiply (one gain bit a cycle) runs beside the cordic, then the blend multiply.
// in_i.ready is high only while no item is in work; a finished result sits in the
// output register, so the next item is taken while it waits.
// reset clears the angle, the sequencer and the output valid and loads register defaults.
module tilt_complementary_filter_top import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16  // 8 to 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcf_in_if.sink                in_i,
  tcf_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int GMUL_W = FIELD_W + GAIN_W + 1;
  localparam int BMUL_W = DIFF_W + WEIGHT_W + 1;

  tcf_state_e state_q, state_d;

  logic [GAIN_W-1:0]   gain_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [WEIGHT_W-1:0] weight_eff;

  logic signed [FIELD_W-1:0] angle_q;
  logic signed [FIELD_W-1:0] out_q;
  logic                      out_valid_q;
  logic signed [PRED_W-1:0]  pred_q;
  logic signed [SUM_W-1:0]   sum_q;

  logic signed [GMUL_W-1:0]  gmul_prod;
  logic signed [BMUL_W-1:0]  bmul_prod;
  logic signed [FIELD_W-1:0] acc_angle;
  logic                      gmul_busy, bmul_busy, crd_busy;
  logic                      accept, pred_load, bmul_start, sum_load, res_load;
  logic signed [PRED_W-1:0]  pred_d;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [SUM_W-33:0]  res_wide;
  logic signed [FIELD_W-1:0] res;

  assign accept     = in_i.valid && (state_q == ST_IDLE);
  assign pred_load  = (state_q == ST_RUN) && !gmul_busy && !crd_busy;
  assign bmul_start = (state_q == ST_PRED);
  assign sum_load   = (state_q == ST_BLEND) && !bmul_busy;
  assign res_load   = (state_q == ST_SAT) && (!out_valid_q || out_o.ready);

  assign weight_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

  tcf_serial_mul #(
    .AW (FIELD_W),
    .BW (GAIN_W)
  ) u_gyro_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .a_i     (in_i.gyro_rate),
    .b_i     (gain_q),
    .busy_o  (gmul_busy),
    .prod_o  (gmul_prod)
  );

  tcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .side_i  (in_i.accel_side),
    .up_i    (in_i.accel_up),
    .busy_o  (crd_busy),
    .angle_o (acc_angle)
  );

  // sum = pred * 2^16 + w * (acc * 2^16 - pred)
  assign pred_d = signed'({{(PRED_W-FIELD_W-16){angle_q[FIELD_W-1]}}, angle_q, 16'b0})
                  + gmul_prod;
  assign diff   = signed'({{(DIFF_W-FIELD_W-16){acc_angle[FIELD_W-1]}}, acc_angle, 16'b0})
                  - signed'({pred_q[PRED_W-1], pred_q});

  tcf_serial_mul #(
    .AW (DIFF_W),
    .BW (WEIGHT_W)
  ) u_blend_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bmul_start),
    .a_i     (diff),
    .b_i     (weight_eff),
    .busy_o  (bmul_busy),
    .prod_o  (bmul_prod)
  );

  assign sum_d = signed'({{(SUM_W-PRED_W-16){pred_q[PRED_W-1]}}, pred_q, 16'b0})
                 + signed'({bmul_prod[BMUL_W-1], bmul_prod}) + ROUND_Q32;

  // saturate the q32-rounded result to the field range
  always_comb begin
    res_wide = signed'(sum_q[SUM_W-1:32]);
    if (res_wide > signed'({{(SUM_W-32-FIELD_W){1'b0}}, SAT_MAX})) begin
      res = SAT_MAX;
    end else if (res_wide < signed'({{(SUM_W-32-FIELD_W){1'b1}}, SAT_MIN})) begin
      res = SAT_MIN;
    end else begin
      res = res_wide[FIELD_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RUN;
      ST_RUN:   if (pred_load) state_d = ST_PRED;
      ST_PRED:  state_d = ST_BLEND;
      ST_BLEND: if (sum_load) state_d = ST_SAT;
      ST_SAT:   if (res_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      angle_q     <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= GAIN_RESET;
      weight_q    <= WEIGHT_RESET;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        angle_q     <= res;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GYRO_STEP_GAIN: gain_q   <= cfg_data_i;
          REG_BLEND_WEIGHT:   weight_q <= cfg_data_i[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pred_load) begin
      pred_q <= pred_d;
    end
    if (sum_load) begin
      sum_q <= sum_d;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.tilt_angle = out_q;

endmodule
